/* hdl/sbs_pkg.sv */
// Shared types and constants of the spectrum bin shaper.
// Used by every module under hdl; depends on nothing.
package sbs_pkg;

  localparam int GRID_SIZE   = 1024;
  localparam int TABLE_DEPTH = 1024;
  localparam int TAB_AW      = $clog2(TABLE_DEPTH);
  localparam int NCNT_W      = TAB_AW + 1;
  localparam int CRD_W       = 10;
  localparam int CNT_W       = 11;
  localparam int D2_W        = 2 * CRD_W + 1;
  localparam int ROOT_W      = (D2_W + 32 + 1) / 2;
  localparam int LAST_W      = 32 + NCNT_W + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [ROOT_W-1:0] DIST_TINY = ROOT_W'(32768);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SCALE = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_K_FIRST     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_K_STEP      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_COUNT = 2'd2;

  typedef struct packed {
    logic                    command;
    logic [9:0]              table_index;
    logic [31:0]             table_value;
    logic [CRD_W-1:0]        bin_x;
    logic [CRD_W-1:0]        bin_y;
    logic signed [31:0]      real_in;
    logic signed [31:0]      imag_in;
  } in_t;

  typedef struct packed {
    logic [CRD_W-1:0]        out_x;
    logic [CRD_W-1:0]        out_y;
    logic signed [31:0]      real_out;
    logic signed [31:0]      imag_out;
  } out_t;

  // Classified item: a load carries its index in x and its value in re.
  typedef struct packed {
    logic                    is_scale;
    logic [CRD_W-1:0]        x;
    logic [CRD_W-1:0]        y;
    logic [31:0]             re;
    logic [31:0]             im;
    logic [D2_W-1:0]         d2;
  } item_t;

  typedef struct packed {
    logic [31:0]             k_first;
    logic [31:0]             step;
    logic [NCNT_W-1:0]       n;
    logic [LAST_W-1:0]       last;
  } shape_t;

endpackage

/* hdl/sbs_front.sv */
// Front end: takes input items, classifies them and folds bin coordinates.
// Depends on sbs_pkg.
module sbs_front import sbs_pkg::*; (
  input  logic  in_valid,
  output logic  in_ready,
  input  in_t   in_data,
  input  logic  q_full,
  output logic  q_push,
  output item_t q_item
);

  logic signed [13:0] dx, dy;
  logic [CRD_W-1:0]   ax, ay;

  always_comb begin
    if (in_data.bin_x < CRD_W'(GRID_SIZE / 2)) begin
      dx = 14'(in_data.bin_x);
    end else begin
      dx = 14'(GRID_SIZE - 1) - 14'(in_data.bin_x);
    end
    if (in_data.bin_y < CRD_W'(GRID_SIZE / 2)) begin
      dy = 14'(in_data.bin_y);
    end else begin
      dy = 14'(GRID_SIZE - 1) - 14'(in_data.bin_y);
    end
    ax = (dx < 0) ? CRD_W'(-dx) : CRD_W'(dx);
    ay = (dy < 0) ? CRD_W'(-dy) : CRD_W'(dy);
  end

  always_comb begin
    in_ready = !q_full;
    q_push   = in_valid && !q_full;
    q_item.is_scale = (in_data.command == CMD_SCALE);
    q_item.d2 = D2_W'(ax * ax) + D2_W'(ay * ay);
    q_item.y  = in_data.bin_y;
    q_item.im = in_data.imag_in;
    if (in_data.command == CMD_SCALE) begin
      q_item.x  = in_data.bin_x;
      q_item.re = in_data.real_in;
    end else begin
      q_item.x  = in_data.table_index;
      q_item.re = in_data.table_value;
    end
  end

endmodule

/* hdl/sbs_queue.sv */
// Short item queue between the front end and the back end.
// Depends on sbs_pkg.
module sbs_queue import sbs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output item_t head
);

  item_t               mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_r, rd_r;
  logic [QUEUE_AW:0]   cnt_r;

  assign full  = (cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue count out of range");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_r - rd_r) == cnt_r[QUEUE_AW-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

/* hdl/sbs_back.sv */
// Back end: square root, table position search, interpolation and scaling.
// Holds the power table. Depends on sbs_pkg.
module sbs_back import sbs_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  shape_t shape,
  input  logic   q_empty,
  input  item_t  q_head,
  output logic   q_pop,
  output logic   out_valid,
  input  logic   out_ready,
  output out_t   out_data
);

  typedef struct packed {
    logic              v;
    item_t             it;
    logic [ROOT_W+1:0] rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic              v;
    item_t             it;
    logic              below;
    logic              high;
    logic [ROOT_W-1:0] off;
    logic [32:0]       rem;
    logic [ROOT_W-1:0] quo;
  } dv_t;

  typedef struct packed {
    logic              v;
    item_t             it;
    logic [TAB_AW-1:0] a0;
    logic [TAB_AW-1:0] a1;
    logic [31:0]       w0;
    logic [31:0]       w1;
    logic              use1;
  } ad_t;

  typedef struct packed {
    logic              v;
    item_t             it;
    logic [31:0]       w0;
    logic [31:0]       w1;
    logic              use1;
  } mm_t;

  typedef struct packed {
    logic              v;
    item_t             it;
    logic [63:0]       m0;
    logic [63:0]       m1;
  } pr_t;

  typedef struct packed {
    logic              v;
    item_t             it;
    logic [32:0]       rem;
    logic [31:0]       low;
    logic [31:0]       quo;
  } g2_t;

  typedef struct packed {
    logic              v;
    logic [CRD_W-1:0]  x;
    logic [CRD_W-1:0]  y;
    logic              neg_re;
    logic              neg_im;
    logic [63:0]       p_re;
    logic [63:0]       p_im;
  } sc_t;

  logic        en;
  sq_t         sq_r [ROOT_W+1];
  dv_t         dv_r [ROOT_W+1];
  ad_t         ad_r;
  mm_t         mm_r;
  pr_t         pr_r;
  g2_t         g2_r [33];
  sc_t         sc_r;
  logic [31:0] tab_r [TABLE_DEPTH];
  logic [31:0] rd0_r, rd1_r;
  logic        out_valid_r;
  out_t        out_r;

  assign en        = !out_valid_r || out_ready;
  assign q_pop     = en && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // square root of d2 * 2^32, one root bit per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r[0].v <= 1'b0;
    end else if (en) begin
      sq_r[0].v    <= !q_empty;
      sq_r[0].it   <= q_head;
      sq_r[0].rem  <= '0;
      sq_r[0].root <= '0;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sq
    localparam int B = ROOT_W - 1 - k;
    logic [2*ROOT_W-1:0] rad;
    logic [ROOT_W+1:0]   rsh, trial;
    logic                take;
    always_comb begin
      rad   = (2*ROOT_W)'({sq_r[k].it.d2, 32'b0});
      rsh   = {sq_r[k].rem[ROOT_W-1:0], rad[2*B+1 -: 2]};
      trial = {sq_r[k].root, 2'b01};
      take  = (rsh >= trial);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_r[k+1].v <= 1'b0;
      end else if (en) begin
        sq_r[k+1].v    <= sq_r[k].v;
        sq_r[k+1].it   <= sq_r[k].it;
        sq_r[k+1].rem  <= take ? (rsh - trial) : rsh;
        sq_r[k+1].root <= {sq_r[k].root[ROOT_W-2:0], take};
      end
    end
  end

  // classify distance against table range
  logic [ROOT_W-1:0] radius;
  always_comb begin
    radius = (sq_r[ROOT_W].it.d2 == '0) ? DIST_TINY : sq_r[ROOT_W].root;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0].v <= 1'b0;
    end else if (en) begin
      dv_r[0].v     <= sq_r[ROOT_W].v;
      dv_r[0].it    <= sq_r[ROOT_W].it;
      dv_r[0].below <= (32'(radius) < shape.k_first);
      dv_r[0].high  <= (LAST_W'(radius) >= shape.last);
      dv_r[0].off   <= radius - shape.k_first[ROOT_W-1:0];
      dv_r[0].rem   <= '0;
      dv_r[0].quo   <= '0;
    end
  end

  // offset / step, one quotient bit per stage
  for (genvar k = 0; k < ROOT_W; k++) begin : g_dv
    logic [32:0] rs;
    logic        take;
    always_comb begin
      rs   = {dv_r[k].rem[31:0], dv_r[k].off[ROOT_W-1-k]};
      take = (rs >= {1'b0, shape.step});
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1].v <= 1'b0;
      end else if (en) begin
        dv_r[k+1].v     <= dv_r[k].v;
        dv_r[k+1].it    <= dv_r[k].it;
        dv_r[k+1].below <= dv_r[k].below;
        dv_r[k+1].high  <= dv_r[k].high;
        dv_r[k+1].off   <= dv_r[k].off;
        dv_r[k+1].rem   <= take ? (rs - {1'b0, shape.step}) : rs;
        dv_r[k+1].quo   <= {dv_r[k].quo[ROOT_W-2:0], take};
      end
    end
  end

  // pick entries and weights
  logic [ROOT_W-1:0] p;
  logic [31:0]       r_eff;
  logic [TAB_AW-1:0] a0_nxt;
  logic              clamp_hi;
  always_comb begin
    p        = dv_r[ROOT_W].quo;
    clamp_hi = dv_r[ROOT_W].high ||
               ((ROOT_W+1)'(p) + 1'b1 >= (ROOT_W+1)'(shape.n));
    if (dv_r[ROOT_W].below) begin
      a0_nxt = '0;
      r_eff  = '0;
    end else if (clamp_hi) begin
      a0_nxt = TAB_AW'(shape.n - 1'b1);
      r_eff  = '0;
    end else begin
      a0_nxt = p[TAB_AW-1:0];
      r_eff  = dv_r[ROOT_W].rem[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ad_r.v <= 1'b0;
    end else if (en) begin
      ad_r.v    <= dv_r[ROOT_W].v;
      ad_r.it   <= dv_r[ROOT_W].it;
      ad_r.a0   <= a0_nxt;
      ad_r.a1   <= p[TAB_AW-1:0] + 1'b1;
      ad_r.w0   <= shape.step - r_eff;
      ad_r.w1   <= r_eff;
      ad_r.use1 <= (r_eff != '0);
    end
  end

  // power table: loads write in item order, scales read two entries
  logic wr_en;
  assign wr_en = en && ad_r.v && !ad_r.it.is_scale &&
                 ({3'b0, ad_r.it.x} < 13'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tab_r[TAB_AW'(ad_r.it.x)] <= ad_r.it.re;
    end
    if (en) begin
      rd0_r <= tab_r[ad_r.a0];
      rd1_r <= tab_r[ad_r.a1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_r.v <= 1'b0;
    end else if (en) begin
      mm_r.v    <= ad_r.v && ad_r.it.is_scale;
      mm_r.it   <= ad_r.it;
      mm_r.w0   <= ad_r.w0;
      mm_r.w1   <= ad_r.w1;
      mm_r.use1 <= ad_r.use1;
    end
  end

  // weighted products
  logic [31:0] f1;
  assign f1 = mm_r.use1 ? rd1_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_r.v <= 1'b0;
    end else if (en) begin
      pr_r.v  <= mm_r.v;
      pr_r.it <= mm_r.it;
      pr_r.m0 <= 64'(rd0_r) * 64'(mm_r.w0);
      pr_r.m1 <= 64'(f1) * 64'(mm_r.w1);
    end
  end

  logic [64:0] num;
  assign num = 65'(pr_r.m0) + 65'(pr_r.m1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g2_r[0].v <= 1'b0;
    end else if (en) begin
      g2_r[0].v   <= pr_r.v;
      g2_r[0].it  <= pr_r.it;
      g2_r[0].rem <= num[64:32];
      g2_r[0].low <= num[31:0];
      g2_r[0].quo <= '0;
    end
  end

  // weighted sum / step, one gain bit per stage
  for (genvar k = 0; k < 32; k++) begin : g_g2
    logic [32:0] rs;
    logic        take;
    always_comb begin
      rs   = {g2_r[k].rem[31:0], g2_r[k].low[31-k]};
      take = (rs >= {1'b0, shape.step});
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        g2_r[k+1].v <= 1'b0;
      end else if (en) begin
        g2_r[k+1].v   <= g2_r[k].v;
        g2_r[k+1].it  <= g2_r[k].it;
        g2_r[k+1].low <= g2_r[k].low;
        g2_r[k+1].rem <= take ? (rs - {1'b0, shape.step}) : rs;
        g2_r[k+1].quo <= {g2_r[k].quo[30:0], take};
      end
    end
  end

  // magnitude times gain
  logic [31:0] mag_re, mag_im;
  always_comb begin
    mag_re = g2_r[32].it.re[31] ? (32'd0 - g2_r[32].it.re) : g2_r[32].it.re;
    mag_im = g2_r[32].it.im[31] ? (32'd0 - g2_r[32].it.im) : g2_r[32].it.im;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_r.v <= 1'b0;
    end else if (en) begin
      sc_r.v      <= g2_r[32].v;
      sc_r.x      <= g2_r[32].it.x;
      sc_r.y      <= g2_r[32].it.y;
      sc_r.neg_re <= g2_r[32].it.re[31];
      sc_r.neg_im <= g2_r[32].it.im[31];
      sc_r.p_re   <= 64'(mag_re) * 64'(g2_r[32].quo);
      sc_r.p_im   <= 64'(mag_im) * 64'(g2_r[32].quo);
    end
  end

  // round toward minus infinity and saturate
  function automatic logic [31:0] sat_part(input logic neg, input logic [63:0] m);
    logic [64:0] sum;
    logic [48:0] q;
    begin
      if (neg) begin
        sum = 65'(m) + 65'd65535;
        q   = sum[64:16];
        if (q > 49'h80000000) begin
          q = 49'h80000000;
        end
        sat_part = 32'd0 - q[31:0];
      end else begin
        q = {1'b0, m[63:16]};
        if (q > 49'h7FFFFFFF) begin
          q = 49'h7FFFFFFF;
        end
        sat_part = q[31:0];
      end
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sc_r.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.out_x    <= sc_r.x;
      out_r.out_y    <= sc_r.y;
      out_r.real_out <= sat_part(sc_r.neg_re, sc_r.p_re);
      out_r.imag_out <= sat_part(sc_r.neg_im, sc_r.p_im);
    end
  end

endmodule

/* hdl/spectrum_bin_shaper_top.sv */
// Spectrum bin shaper: top level with configuration registers.
// Depends on sbs_pkg, sbs_front, sbs_queue and sbs_back.
//
// Accepts one item per clock and delivers one scaled bin per clock when the
// result side keeps up. Without stalls on the result side, the delay of a
// scale item from being taken to appearing is set by the bit-per-stage
// square root pipeline, the position division pipeline and the
// interpolation division pipeline. Load items write the power table in item
// order with scale items and give no result. A configuration write reaches
// the back end through the configuration registers and the registered shape.
module spectrum_bin_shaper_top import sbs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [31:0]      k_first_r, k_step_r;
  logic [CNT_W-1:0] table_count_r;
  shape_t           shape_r;
  logic [31:0]      step_fix;
  logic [NCNT_W-1:0] n_fix;

  logic  q_full, q_push, q_pop, q_empty;
  item_t q_item, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_first_r     <= '0;
      k_step_r      <= 32'd65536;
      table_count_r <= CNT_W'(1024);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_K_FIRST:     k_first_r     <= cfg_data;
        CFG_K_STEP:      k_step_r      <= cfg_data;
        CFG_TABLE_COUNT: table_count_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    step_fix = (k_step_r == '0) ? 32'd1 : k_step_r;
    if (table_count_r < CNT_W'(2)) begin
      n_fix = NCNT_W'(2);
    end else if (13'(table_count_r) > 13'(TABLE_DEPTH)) begin
      n_fix = NCNT_W'(TABLE_DEPTH);
    end else begin
      n_fix = NCNT_W'(table_count_r);
    end
  end

  always_ff @(posedge clk) begin
    shape_r.k_first <= k_first_r;
    shape_r.step    <= step_fix;
    shape_r.n       <= n_fix;
    shape_r.last    <= LAST_W'(k_first_r) +
                       LAST_W'(64'(n_fix - 1'b1) * 64'(step_fix));
  end

  sbs_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  sbs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  sbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .shape     (shape_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench of the spectrum bin shaper: loads the power table,
// scales bins under several register settings and checks every result.
// Depends on sbs_pkg and spectrum_bin_shaper_top.
module tb_top;
  import sbs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 120;
  localparam int WD_LIMIT    = 20000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_K_FIRST;
  logic [31:0] cfg_data = '0;

  always #4 clk = ~clk;

  spectrum_bin_shaper_top u_top (.*);

  logic [31:0] k_first_m;
  logic [31:0] k_step_m;
  logic [10:0] count_m;
  logic [31:0] power_m [TABLE_DEPTH];
  out_t scaled_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_off = 0;
  int hold_gen = 0;
  int hold_seen = 0;
  bit rx_stall_rand = 1'b1;

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] fold_sq(logic [9:0] c);
    longint d;
    if (c < GRID_SIZE / 2) d = c;
    else d = GRID_SIZE - 1 - longint'(c);
    if (d < 0) d = -d;
    return d * d;
  endfunction

  function automatic logic [63:0] radial_power(logic [63:0] x0);
    logic [63:0] n, stp, last, off, p, r;
    n = count_m;
    stp = (k_step_m != 0) ? k_step_m : 1;
    if (n < 2) n = 2;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    last = k_first_m + (n - 1) * stp;
    if (x0 < k_first_m) return power_m[0];
    if (x0 >= last) return power_m[n-1];
    off = x0 - k_first_m;
    p = off / stp;
    r = off % stp;
    if (p + 1 >= n) return power_m[n-1];
    if (r == 0) return power_m[p];
    return (power_m[p] * (stp - r) + power_m[p+1] * r) / stp;
  endfunction

  function automatic logic [31:0] scale_sat(logic [31:0] u, logic [63:0] g);
    logic neg;
    logic [63:0] mag, q;
    neg = u[31];
    mag = neg ? (64'h1_0000_0000 - u) : u;
    if (neg) begin
      q = (mag * g + 65535) >> 16;
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return 32'(~q + 1);
    end
    q = (mag * g) >> 16;
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic void predict(in_t it);
    logic [63:0] d2, dist_m, g;
    out_t e;
    if (it.command == CMD_LOAD) begin
      power_m[it.table_index] = it.table_value;
      return;
    end
    d2 = fold_sq(it.bin_x) + fold_sq(it.bin_y);
    dist_m = (d2 == 0) ? 64'd32768 : isqrt(d2 << 32);
    g = radial_power(dist_m);
    e.out_x = it.bin_x;
    e.out_y = it.bin_y;
    e.real_out = scale_sat(it.real_in, g);
    e.imag_out = scale_sat(it.imag_in, g);
    scaled_q.push_back(e);
  endfunction

  task automatic send_item(in_t it, bit gaps = 1'b1);
    int w;
    w = gaps ? $urandom_range(0, 10) : 0;
    if ($urandom_range(0, 3) == 0) w = 0;
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (scaled_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_K_FIRST: k_first_m = val;
      CFG_K_STEP: k_step_m = val;
      CFG_TABLE_COUNT: count_m = val[10:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic in_t load_of(int idx, logic [31:0] v);
    in_t it;
    it = '0;
    it.command = CMD_LOAD;
    it.table_index = 10'(idx);
    it.table_value = v;
    it.bin_x = CRD_W'($urandom);
    it.bin_y = CRD_W'($urandom);
    it.real_in = $urandom;
    it.imag_in = $urandom;
    return it;
  endfunction

  function automatic in_t bin_of(int x, int y, logic [31:0] re, logic [31:0] im);
    in_t it;
    it.command = CMD_SCALE;
    it.table_index = 10'($urandom);
    it.table_value = $urandom;
    it.bin_x = CRD_W'(x);
    it.bin_y = CRD_W'(y);
    it.real_in = re;
    it.imag_in = im;
    return it;
  endfunction

  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(int'($urandom_range(0, 131072)) - 65536);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_power();
    case ($urandom_range(0, 4))
      0: return 32'hFFFF_FFFF;
      1: return 32'd0;
      2: return $urandom_range(0, 32'h0002_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic fill_table();
    for (int i = 0; i < TABLE_DEPTH; i++) send_item(load_of(i, rand_power()), 1'b0);
  endtask

  task automatic test_directed();
    fill_table();
    send_item(bin_of(0, 0, 32'h0001_0000, 32'hFFFF_0000));
    send_item(bin_of(0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
    send_item(bin_of(1023, 1023, 32'h8000_0000, 32'h7FFF_FFFF));
    send_item(bin_of(511, 512, 32'h0000_0001, 32'hFFFF_FFFF));
    send_item(bin_of(3, 4, 32'h0002_0000, 32'h0));
    send_item(bin_of(1, 0, 32'h1234_5678, 32'hEDCB_A988));
    send_item(load_of(5, 32'hFFFF_FFFF));
    send_item(bin_of(5, 0, 32'h7FFF_FFFF, 32'h8000_0001));
    send_item(bin_of(300, 700, $urandom, $urandom));
    drain();
  endtask

  task automatic test_config(logic [31:0] kf, logic [31:0] ks, logic [31:0] cnt, int nitems);
    in_t it;
    write_reg(CFG_K_FIRST, kf);
    write_reg(CFG_K_STEP, ks);
    write_reg(CFG_TABLE_COUNT, cnt);
    for (int i = 0; i < nitems; i++) begin
      if ($urandom_range(0, 9) == 0) it = load_of($urandom_range(0, 1023), rand_power());
      else if ($urandom_range(0, 7) == 0)
        it = bin_of($urandom_range(0, 3) == 0 ? 0 : 1023, $urandom_range(0, 1023),
                    rand_part(), rand_part());
      else it = bin_of($urandom, $urandom, rand_part(), rand_part());
      send_item(it);
    end
    drain();
  endtask

  task automatic test_backpressure();
    rx_stall_rand = 1'b0;
    hold_gen++;
    for (int i = 0; i < 130; i++) send_item(bin_of($urandom, $urandom, $urandom, $urandom), 1'b0);
    rx_stall_rand = 1'b1;
    drain();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (scaled_q.size() == 0) begin
        $error("unexpected result x=%0d y=%0d", out_data.out_x, out_data.out_y);
        errors++;
      end else begin
        out_t e;
        e = scaled_q.pop_front();
        if (out_data.out_x !== e.out_x) begin
          $error("out_x expected %0d actual %0d", e.out_x, out_data.out_x); errors++;
        end
        if (out_data.out_y !== e.out_y) begin
          $error("out_y expected %0d actual %0d", e.out_y, out_data.out_y); errors++;
        end
        if (out_data.real_out !== e.real_out) begin
          $error("real_out expected %0d actual %0d", e.real_out, out_data.real_out); errors++;
        end
        if (out_data.imag_out !== e.imag_out) begin
          $error("imag_out expected %0d actual %0d", e.imag_out, out_data.imag_out); errors++;
        end
      end
    end
  end

  int rx_wait = 0;
  always @(posedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen <= hold_gen;
      hold_off <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (!rx_stall_rand) begin
      out_ready <= 1'b1;
    end else if (out_valid && out_ready) begin
      rx_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
      out_ready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= (rx_wait == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || hold_off > 0)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    k_first_m = 0;
    k_step_m = 32'd65536;
    count_m = 11'd1024;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_config(32'h0, 32'h0001_0000, 32'd1024, 60);
    test_config(32'h0010_0000, 32'h0000_8000, 32'd2, 40);
    test_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1024, 30);
    test_config(32'h0, 32'h0000_0001, 32'd1024, 40);
    test_config(32'h0, 32'h0, 32'd700, 30);
    test_config(32'h0008_0000, 32'h0002_3456, 32'd300, 50);
    test_config(32'h0, 32'h0000_1000, 32'd1024, 40);
    test_config(32'h0, 32'h0000_B505, 32'd1024, 40);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

/* files.f */
hdl/sbs_pkg.sv
hdl/sbs_front.sv
hdl/sbs_queue.sv
hdl/sbs_back.sv
hdl/spectrum_bin_shaper_top.sv
tb/tb_top.sv
